// ----- rtl/core/phe_pkg.sv -----
// Shared widths, register indexes and control structs for the Horner evaluator.
package phe_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int DEG_W     = 3;
  localparam int CFG_IDX_W = 3;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_DEGREE_DEF = 6;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = CFG_IDX_W'(1);

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture point, seed accumulator with the top coefficient
    logic mul;    // register acc * x
    logic add;    // shift, saturate, add next coefficient
    logic emit;   // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic idx_zero;  // no coefficients left to fold in
  } sts_t;

endpackage

// ----- rtl/core/phe_if.sv -----
// Channel interfaces: points in, results out, configuration writes.
interface phe_point_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [phe_pkg::DATA_W-1:0]      point;
  modport source (output valid, output point, input ready);
  modport sink   (input valid, input point, output ready);
endinterface

interface phe_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [phe_pkg::DATA_W-1:0]      value;
  logic                                   overflow;
  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

interface phe_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [phe_pkg::CFG_IDX_W-1:0]          index;
  logic [phe_pkg::DATA_W-1:0]             data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/phe_dp.sv -----
// Datapath: configuration registers, accumulator, shared multiplier and saturating adder.
module phe_dp #(
  parameter int FRAC_BITS  = phe_pkg::FRAC_BITS_DEF,
  parameter int MAX_DEGREE = phe_pkg::MAX_DEGREE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [phe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [phe_pkg::DATA_W-1:0]            cfg_data,
  input  logic signed [phe_pkg::DATA_W-1:0]     point_in,
  input  phe_pkg::cmd_t                         cmd,
  output phe_pkg::sts_t                         sts,
  output logic signed [phe_pkg::DATA_W-1:0]     value,
  output logic                                  overflow
);

  localparam int COEF_N = MAX_DEGREE + 1;
  localparam int CI_W   = (COEF_N > 1) ? $clog2(COEF_N) : 1;
  localparam logic [phe_pkg::DEG_W-1:0] DEG_CAP = phe_pkg::DEG_W'(MAX_DEGREE);
  localparam logic signed [phe_pkg::PROD_W-1:0] WIDE_MAX =
    phe_pkg::PROD_W'(phe_pkg::DATA_MAX);
  localparam logic signed [phe_pkg::PROD_W-1:0] WIDE_MIN =
    phe_pkg::PROD_W'(phe_pkg::DATA_MIN);

  logic [phe_pkg::DEG_W-1:0]              degree;
  logic signed [phe_pkg::DATA_W-1:0]      coef [COEF_N];
  logic signed [phe_pkg::DATA_W-1:0]      x;
  logic signed [phe_pkg::DATA_W-1:0]      acc;
  logic signed [phe_pkg::PROD_W-1:0]      prod;
  logic [phe_pkg::DEG_W-1:0]              idx;
  logic                                   ovf;

  logic [phe_pkg::DEG_W-1:0]              deg_eff;
  logic [phe_pkg::DEG_W-1:0]              idx_m1;
  logic [phe_pkg::DEG_W-1:0]              sel;
  logic signed [phe_pkg::DATA_W-1:0]      coef_rd;
  logic signed [phe_pkg::PROD_W-1:0]      shifted;
  logic                                   prod_ovf;
  logic signed [phe_pkg::DATA_W-1:0]      prod_sat;
  logic signed [phe_pkg::DATA_W:0]        sum;
  logic                                   sum_ovf;
  logic signed [phe_pkg::DATA_W-1:0]      acc_next;

  assign deg_eff = (degree > DEG_CAP) ? DEG_CAP : degree;
  assign idx_m1  = idx - 1'b1;
  assign sel     = cmd.load ? deg_eff : idx_m1;
  assign coef_rd = (sel <= DEG_CAP) ? coef[sel[CI_W-1:0]] : '0;

  // Floor shift, then clamp the product to the data range
  assign shifted  = prod >>> FRAC_BITS;
  assign prod_ovf = (shifted > WIDE_MAX) || (shifted < WIDE_MIN);
  always_comb begin
    if (shifted > WIDE_MAX) begin
      prod_sat = phe_pkg::DATA_MAX;
    end else if (shifted < WIDE_MIN) begin
      prod_sat = phe_pkg::DATA_MIN;
    end else begin
      prod_sat = shifted[phe_pkg::DATA_W-1:0];
    end
  end

  assign sum     = {prod_sat[phe_pkg::DATA_W-1], prod_sat} +
                   {coef_rd[phe_pkg::DATA_W-1], coef_rd};
  assign sum_ovf = sum[phe_pkg::DATA_W] != sum[phe_pkg::DATA_W-1];
  always_comb begin
    if (!sum_ovf) begin
      acc_next = sum[phe_pkg::DATA_W-1:0];
    end else if (sum[phe_pkg::DATA_W]) begin
      acc_next = phe_pkg::DATA_MIN;
    end else begin
      acc_next = phe_pkg::DATA_MAX;
    end
  end

  assign sts.idx_zero = (idx == '0);

  // Configuration registers; indexes past the stored coefficients are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= '0;
      for (int k = 0; k < COEF_N; k++) begin
        coef[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == phe_pkg::REG_DEGREE) begin
        degree <= cfg_data[phe_pkg::DEG_W-1:0];
      end
      for (int k = 0; k < COEF_N; k++) begin
        if (cfg_index == phe_pkg::REG_COEF0 + phe_pkg::CFG_IDX_W'(k)) begin
          coef[k] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x   <= point_in;
      acc <= coef_rd;
      idx <= deg_eff;
      ovf <= 1'b0;
    end
    if (cmd.mul) begin
      prod <= acc * x;
    end
    if (cmd.add) begin
      acc <= acc_next;
      idx <= idx_m1;
      ovf <= ovf | prod_ovf | sum_ovf;
    end
    if (cmd.emit) begin
      value    <= acc;
      overflow <= ovf;
    end
  end

endmodule

// ----- rtl/core/phe_ctrl.sv -----
// Controller: sequences load, multiply and add steps and owns the output valid.
module phe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  phe_pkg::sts_t sts,
  output phe_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_ADD,
    S_DONE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.mul  = (state == S_STEP) && !sts.idx_zero;
  assign cmd.add  = (state == S_ADD);
  assign cmd.emit = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.load) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          state <= sts.idx_zero ? S_DONE : S_ADD;
        end
        S_ADD: begin
          state <= S_STEP;
        end
        S_DONE: begin
          if (cmd.emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/polynomial_horner_evaluator_top.sv -----
// Top level of the fixed-point Horner polynomial evaluator.
//
//   channel   dir  word contents                 accepted when
//   points    in   point (signed Q16.16)         points.valid && points.ready
//   results   out  value (signed), overflow      results.valid && results.ready
//   cfg       in   index, data                   cfg.valid && cfg.ready
//
// A point is evaluated in n coefficient steps, with n the effective degree (degree
// clamped to MAX_DEGREE): each step multiplies on the shared 32x32 multiplier, then
// shifts, saturates and adds. One point is evaluated at a time.
// The result sits in an output register; a stalled result holds the last step only
// until the register frees, then the next point is taken.
// rst is synchronous, active high: degree and all coefficients clear to zero.
// cfg is always ready; write it only while no point is in flight.
module polynomial_horner_evaluator_top #(
  parameter int FRAC_BITS  = phe_pkg::FRAC_BITS_DEF,
  parameter int MAX_DEGREE = phe_pkg::MAX_DEGREE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  phe_point_if.sink   points,
  phe_result_if.source results,
  phe_cfg_if.sink     cfg
);

  phe_pkg::cmd_t cmd;
  phe_pkg::sts_t sts;

  // Registers take every write offered
  assign cfg.ready = 1'b1;

  phe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_ready  (points.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  phe_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .point_in  (points.point),
    .cmd       (cmd),
    .sts       (sts),
    .value     (results.value),
    .overflow  (results.overflow)
  );

`ifndef NO_ASSERTIONS
  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  // An add always consumes the product registered the cycle before
  a_add_after_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.add |-> $past(cmd.mul))
    else $error("add without a preceding multiply");

  // Never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!results.valid || results.ready))
    else $error("result register overwritten while stalled");

  // No new point while a result is being produced
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul || cmd.add) |=> !cmd.load)
    else $error("point accepted during an evaluation");
`endif

endmodule
